// ----- hdl/hard_rod_lattice_mc_step_top_macros.svh -----
// Assertion macros for the rod lattice block
`ifndef HARD_ROD_LATTICE_MC_STEP_TOP_MACROS_SVH
`define HARD_ROD_LATTICE_MC_STEP_TOP_MACROS_SVH

// Implication checked on every rising clock edge outside reset
`define HRL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset
`define HRL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/hrl_pkg.sv -----
package hrl_pkg;
    localparam int GRID_SIDE_DEF  = 64;
    localparam int ROD_LENGTH_DEF = 8;
    localparam int LIST_DEPTH_DEF = 512;
    localparam int DRAW_BITS_DEF  = 16;

    localparam int ACT_W   = 24;
    localparam int CNT_W   = 10;
    localparam int POS_W   = 6;
    localparam int RCNT_W  = 32;
    localparam logic [ACT_W-1:0] ACT_RESET = 24'd36700;

    typedef enum logic [1:0] {
        OUT_REMOVED  = 2'd0,
        OUT_INSERTED = 2'd1,
        OUT_REJECTED = 2'd2,
        OUT_BLOCKED  = 2'd3
    } t_outcome;

    localparam logic [1:0] CELL_EMPTY = 2'd0;
    localparam logic [1:0] CELL_HORIZ = 2'd1;
    localparam logic [1:0] CELL_VERT  = 2'd3;

    localparam int IN_W  = 46;
    localparam int OUT_W = 67;
endpackage

// ----- hdl/hrl_lattice.sv -----
// Cell store: one read or write per cycle once cleared; registered read.
module hrl_lattice #(
    parameter int GRID_SIDE = hrl_pkg::GRID_SIDE_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_clr_en,
    input  logic [$clog2(GRID_SIDE*GRID_SIDE)-1:0] i_addr,
    input  logic                                   i_wr_en,
    input  logic [1:0]                             i_wr_data,
    output logic [1:0]                             o_rd_data,
    output logic                                   o_clr_busy
);
    import hrl_pkg::*;
    localparam int CELLS = GRID_SIDE * GRID_SIDE;
    localparam int AW    = $clog2(CELLS);

    logic [1:0]  r_mem [CELLS];
    logic [AW:0] r_clr_ptr;
    logic [AW-1:0] w_addr;
    logic          w_we;
    logic [1:0]    w_wd;

    // Clearing sweep after reset, one cell a cycle while i_clr_en is high
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_ptr <= '0;
        end else if (i_clr_en && !r_clr_ptr[AW]) begin
            r_clr_ptr <= r_clr_ptr + 1'b1;
        end
    end

    assign o_clr_busy = !r_clr_ptr[AW];
    assign w_addr = o_clr_busy ? r_clr_ptr[AW-1:0] : i_addr;
    assign w_we   = o_clr_busy ? i_clr_en : i_wr_en;
    assign w_wd   = o_clr_busy ? CELL_EMPTY : i_wr_data;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_addr] <= w_wd;
        end
        o_rd_data <= r_mem[w_addr];
    end
endmodule

// ----- hdl/hard_rod_lattice_mc_step_top.sv -----
// Channel   Dir  Bits  Contents
// s_axis    in   48    tdata: action, accept_draw, pick_draw, row, col, orientation
// m_axis    out  72    tdata: outcome, rod_row, rod_col, rod_orientation,
//                      horizontal_total, vertical_total, accepted_removals
// cfg       in   24    activity (write enable + data)
// Steps: S_IDLE, S_DEC; a removal then passes S_PICK, where it may be rejected,
// S_RDEL, one S_SHRD read and one S_SHWR write per list entry shifted down, and
// S_PAINT; an insertion passes S_CHK, where it may be blocked, and S_PAINT.
// Reset: synchronous, active low; afterwards a clearing pass over all
// GRID_SIDE^2 cells (4096 by default) empties the lattice; no request taken.
// One request at a time; the result sits in an output register and a stalled
// result holds off the next request (next accept once it drains).
`include "hard_rod_lattice_mc_step_top_macros.svh"
module hard_rod_lattice_mc_step_top #(
    parameter int ROD_LENGTH = hrl_pkg::ROD_LENGTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [hrl_pkg::ACT_W-1:0] i_cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // action[0], accept_draw[16:1], pick_draw[32:17], row[38:33], col[44:39],
    // orientation[45], zero fill [47:46]
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // outcome[1:0], rod_row[7:2], rod_col[13:8], rod_orientation[14],
    // horizontal_total[24:15], vertical_total[34:25], accepted_removals[66:35],
    // zero fill [71:67]
    output logic [71:0] m_axis_tdata
);
    import hrl_pkg::*;

    // Grid, list and draw sizes are tied to the fixed field widths
    localparam int GRID_SIDE  = GRID_SIDE_DEF;
    localparam int LIST_DEPTH = LIST_DEPTH_DEF;
    localparam int DRAW_BITS  = DRAW_BITS_DEF;

    localparam int GW    = $clog2(GRID_SIDE);
    localparam int AW    = 2 * GW;
    localparam int LW    = $clog2(LIST_DEPTH);
    localparam int KW    = $clog2(ROD_LENGTH + 1);
    // threshold: total * 2^(DRAW_BITS+16) / (2*GRID^2), shift by TSH
    localparam int TSH   = DRAW_BITS + 16 - 1 - AW;
    localparam int LHS_W = DRAW_BITS + ACT_W;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_DEC   = 9'b000000010,
        S_PICK  = 9'b000000100,
        S_RDEL  = 9'b000001000,
        S_SHRD  = 9'b000010000,
        S_SHWR  = 9'b000100000,
        S_CHK   = 9'b001000000,
        S_PAINT = 9'b010000000,
        S_OUT   = 9'b100000000
    } t_state;

    t_state r_state;

    logic [ACT_W-1:0]     r_act;
    logic                 r_action, r_orient;
    logic [DRAW_BITS-1:0] r_adraw, r_pdraw;
    logic [GW-1:0]        r_row, r_col;
    logic [CNT_W-1:0]     r_hcnt, r_vcnt;
    logic [RCNT_W-1:0]    r_rcnt;
    logic [LW:0]          r_idx;
    logic [KW-1:0]        r_k;
    logic                 r_free;
    logic [1:0]           r_code;
    logic                 r_oval;
    logic [OUT_W-1:0]     r_odata;
    logic [LHS_W-1:0]     r_lhs;
    logic [CNT_W:0]       r_total;

    // Rod lists: one array each, single write/read port
    logic [AW-1:0] r_hlist [LIST_DEPTH];
    logic [AW-1:0] r_vlist [LIST_DEPTH];
    logic [AW-1:0] r_lrd;
    logic          w_lwe;
    logic [LW-1:0] w_lwa, w_lra;
    logic [AW-1:0] w_lwd;
    logic          w_lsel;

    // Lattice
    logic [AW-1:0] w_caddr;
    logic          w_cwe;
    logic [1:0]    w_crd;
    logic          w_clr_busy;
    logic [GW-1:0] w_cr, w_cc;

    logic [CNT_W-1:0] w_cnt_sel;
    logic [CNT_W+DRAW_BITS:0] w_prod;
    logic [CNT_W:0]  w_pick;

    hrl_lattice #(.GRID_SIDE(GRID_SIDE)) u_lattice (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clr_en  (1'b1),
        .i_addr    (w_caddr),
        .i_wr_en   (w_cwe),
        .i_wr_data (r_code),
        .o_rd_data (w_crd),
        .o_clr_busy(w_clr_busy)
    );

    assign s_axis_tready = (r_state == S_IDLE) && !w_clr_busy && !r_oval;
    assign m_axis_tvalid = r_oval;
    assign m_axis_tdata  = {{(72-OUT_W){1'b0}}, r_odata};

    // Cell k of the current rod
    always_comb begin
        w_cr = r_row;
        w_cc = r_col;
        if (r_orient) begin
            w_cc = r_col + GW'(r_k);
        end else begin
            w_cr = r_row + GW'(r_k);
        end
        w_caddr = {w_cr, w_cc};
    end
    assign w_cwe = (r_state == S_PAINT) && (r_k < KW'(ROD_LENGTH));

    assign w_cnt_sel = r_orient ? r_hcnt : r_vcnt;
    assign w_prod    = r_pdraw * r_total;
    assign w_pick    = w_prod[CNT_W+DRAW_BITS:DRAW_BITS];

    // List port control
    always_comb begin
        w_lwe  = 1'b0;
        w_lsel = r_orient;
        w_lwa  = r_idx[LW-1:0];
        w_lwd  = r_lrd;
        w_lra  = r_idx[LW-1:0];
        if (r_state == S_PAINT && r_k == '0 && r_action) begin
            w_lwe = 1'b1;
            w_lwa = w_cnt_sel[LW-1:0];
            w_lwd = {r_row, r_col};
        end else if (r_state == S_SHWR) begin
            w_lwe = 1'b1;
        end else if (r_state == S_SHRD) begin
            w_lra = LW'(r_idx + 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_lwe && w_lsel) begin
            r_hlist[w_lwa] <= w_lwd;
        end
        if (w_lwe && !w_lsel) begin
            r_vlist[w_lwa] <= w_lwd;
        end
        r_lrd <= w_lsel ? r_hlist[w_lra] : r_vlist[w_lra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_act   <= ACT_RESET;
            r_hcnt  <= '0;
            r_vcnt  <= '0;
            r_rcnt  <= '0;
            r_oval  <= 1'b0;
            r_k     <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_act <= i_cfg_wr_data;
            end
            if (r_oval && m_axis_tready) begin
                r_oval <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_action <= s_axis_tdata[0];
                        r_adraw  <= s_axis_tdata[16:1];
                        r_pdraw  <= s_axis_tdata[32:17];
                        r_row    <= s_axis_tdata[38:33];
                        r_col    <= s_axis_tdata[44:39];
                        r_orient <= s_axis_tdata[45];
                        r_state  <= S_DEC;
                    end
                end
                S_DEC: begin
                    r_total <= {1'b0, r_hcnt} + {1'b0, r_vcnt};
                    r_lhs   <= r_adraw * r_act;
                    r_k     <= '0;
                    r_free  <= 1'b1;
                    r_code  <= r_orient ? CELL_HORIZ : CELL_VERT;
                    if (r_action) begin
                        r_state <= S_CHK;
                    end else begin
                        r_state <= S_PICK;
                    end
                end
                S_PICK: begin
                    // lhs < ceil(total*2^TSH) <=> lhs < total<<TSH
                    if (r_total != '0 && r_lhs < (LHS_W'(r_total) << TSH)) begin
                        r_rcnt <= r_rcnt + 1'b1;
                        if (w_pick < {1'b0, r_hcnt}) begin
                            r_orient <= 1'b1;
                            r_idx    <= w_pick[LW:0];
                        end else begin
                            r_orient <= 1'b0;
                            r_idx    <= (LW+1)'(w_pick - {1'b0, r_hcnt});
                        end
                        r_state <= S_RDEL;
                        r_k     <= '0;
                    end else begin
                        r_odata <= {r_rcnt, r_vcnt, r_hcnt, 13'd0, OUT_REJECTED};
                        r_oval  <= 1'b1;
                        r_state <= S_OUT;
                    end
                end
                S_RDEL: begin
                    // list read issued here at r_idx; data arrives next cycle
                    if (r_k == '0) begin
                        r_k <= KW'(1);
                    end else begin
                        r_row   <= r_lrd[AW-1:GW];
                        r_col   <= r_lrd[GW-1:0];
                        r_code  <= CELL_EMPTY;
                        r_state <= S_SHRD;
                        r_k     <= '0;
                    end
                end
                S_SHRD: begin
                    if ({1'b0, r_idx} + 1'b1 >= {1'b0, w_cnt_sel}) begin
                        if (r_orient) r_hcnt <= r_hcnt - 1'b1;
                        else          r_vcnt <= r_vcnt - 1'b1;
                        r_state <= S_PAINT;
                    end else begin
                        r_state <= S_SHWR;
                    end
                end
                S_SHWR: begin
                    r_idx   <= r_idx + 1'b1;
                    r_state <= S_SHRD;
                end
                S_CHK: begin
                    // read cell k issued; result of cell k-1 visible
                    if (r_k != '0 && w_crd != CELL_EMPTY) begin
                        r_free <= 1'b0;
                    end
                    if (r_k == KW'(ROD_LENGTH)) begin
                        r_k <= '0;
                        if (w_cnt_sel < CNT_W'(LIST_DEPTH) &&
                            r_free && w_crd == CELL_EMPTY) begin
                            r_state <= S_PAINT;
                        end else begin
                            r_odata <= {r_rcnt, r_vcnt, r_hcnt, 13'd0, OUT_BLOCKED};
                            r_oval  <= 1'b1;
                            r_state <= S_OUT;
                        end
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_PAINT: begin
                    if (r_k == KW'(ROD_LENGTH)) begin
                        if (r_action) begin
                            if (r_orient) begin
                                r_hcnt <= r_hcnt + 1'b1;
                                r_odata <= {r_rcnt, r_vcnt, r_hcnt + 1'b1, r_orient,
                                            r_col, r_row, OUT_INSERTED};
                            end else begin
                                r_vcnt <= r_vcnt + 1'b1;
                                r_odata <= {r_rcnt, r_vcnt + 1'b1, r_hcnt, r_orient,
                                            r_col, r_row, OUT_INSERTED};
                            end
                        end else begin
                            r_odata <= {r_rcnt, r_vcnt, r_hcnt, r_orient,
                                        r_col, r_row, OUT_REMOVED};
                        end
                        r_oval  <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_OUT: begin
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `HRL_ASSERT_IMP(a_no_accept_busy, i_clk, i_rst_n, w_clr_busy, !s_axis_tready,
        "accept during clear")
    `HRL_ASSERT_IMP(a_cnt_bound, i_clk, i_rst_n, 1'b1,
        r_hcnt <= CNT_W'(LIST_DEPTH) && r_vcnt <= CNT_W'(LIST_DEPTH), "count over depth")
    `HRL_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, r_oval && !m_axis_tready,
        r_oval && $stable(r_odata), "result lost")
endmodule

// ----- sim/tb_hard_rod_lattice_mc_step_top.sv -----
`timescale 1ns / 100ps

module tb_hard_rod_lattice_mc_step_top;
    import hrl_pkg::*;

    localparam int SIDE      = 64;
    localparam int RLEN      = 8;
    localparam int DEPTH     = 512;
    localparam int N_RANDOM  = 560;
    // Worst case block latency plus margin, used for idle waits before writes
    localparam int SETTLE    = 2 * DEPTH + 64;

    localparam logic ACT_REMOVE = 1'b0;
    localparam logic ACT_INSERT = 1'b1;
    localparam logic OR_VERT    = 1'b0;
    localparam logic OR_HORIZ   = 1'b1;

    // Request fields as carried on s_axis_tdata
    typedef struct packed {
        logic       orientation;
        logic [5:0] col;
        logic [5:0] row;
        logic [15:0] pick_draw;
        logic [15:0] accept_draw;
        logic       action;
    } t_req;

    // Response fields as carried on m_axis_tdata
    typedef struct packed {
        logic [31:0] accepted_removals;
        logic [9:0]  vertical_total;
        logic [9:0]  horizontal_total;
        logic        rod_orientation;
        logic [5:0]  rod_col;
        logic [5:0]  rod_row;
        t_outcome    outcome;
    } t_rsp;

    // Directed row: expected response is checked only where chk is set
    typedef struct {
        t_req req;
        bit   chk;
        t_rsp rsp;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [23:0] i_cfg_wr_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;

    hard_rod_lattice_mc_step_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        i_clk = 1'b1; #1;
        i_clk = 1'b0; #1;
    end

    // Predictor state: lattice occupancy, rod start lists, counters
    logic [1:0]  occ [SIDE*SIDE];
    logic [11:0] hlist [DEPTH];
    logic [11:0] vlist [DEPTH];
    int unsigned hcnt, vcnt;
    logic [31:0] removals;
    logic [23:0] activity_q;

    t_rsp  rsp_pending [$];
    int    errors;

    // Row-major cell index of segment k of a rod starting at (r, c)
    function automatic int seg_cell(int r, int c, bit horiz, int k);
        if (horiz) c = (c + k) % SIDE;
        else       r = (r + k) % SIDE;
        return r * SIDE + c;
    endfunction

    // Applies one move to the predictor and returns the response it implies
    function automatic t_rsp predict_move(t_req q);
        t_rsp        o;
        longint unsigned tot, thr, lhs;
        int unsigned idx;
        logic [11:0] pk;
        bit          free;
        o = '0;
        if (q.action == ACT_REMOVE) begin
            tot = hcnt + vcnt;
            thr = ((tot << 32) + 2*SIDE*SIDE - 1) / (2*SIDE*SIDE);
            lhs = longint'(q.accept_draw) * longint'(activity_q);
            if (tot > 0 && lhs < thr) begin
                idx = (longint'(q.pick_draw) * tot) >> 16;
                removals++;
                if (idx < hcnt) begin
                    pk = hlist[idx];
                    o.rod_orientation = OR_HORIZ;
                    for (int i = idx; i + 1 < hcnt; i++) hlist[i] = hlist[i+1];
                    hcnt--;
                end else begin
                    idx -= hcnt;
                    pk = vlist[idx];
                    o.rod_orientation = OR_VERT;
                    for (int i = idx; i + 1 < vcnt; i++) vlist[i] = vlist[i+1];
                    vcnt--;
                end
                o.rod_row = pk[11:6];
                o.rod_col = pk[5:0];
                for (int k = 0; k < RLEN; k++)
                    occ[seg_cell(o.rod_row, o.rod_col, o.rod_orientation, k)] = CELL_EMPTY;
                o.outcome = OUT_REMOVED;
            end else begin
                o.outcome = OUT_REJECTED;
            end
        end else begin
            free = ((q.orientation ? hcnt : vcnt) < DEPTH);
            for (int k = 0; k < RLEN; k++)
                if (occ[seg_cell(q.row, q.col, q.orientation, k)] != CELL_EMPTY) free = 0;
            if (free) begin
                if (q.orientation) begin
                    hlist[hcnt] = {q.row, q.col};
                    hcnt++;
                end else begin
                    vlist[vcnt] = {q.row, q.col};
                    vcnt++;
                end
                for (int k = 0; k < RLEN; k++)
                    occ[seg_cell(q.row, q.col, q.orientation, k)] =
                        q.orientation ? CELL_HORIZ : CELL_VERT;
                o.rod_row = q.row;
                o.rod_col = q.col;
                o.rod_orientation = q.orientation;
                o.outcome = OUT_INSERTED;
            end else begin
                o.outcome = OUT_BLOCKED;
            end
        end
        o.horizontal_total  = hcnt[9:0];
        o.vertical_total    = vcnt[9:0];
        o.accepted_removals = removals;
        return o;
    endfunction

    function automatic t_req mk_req(logic act, logic [15:0] ad, logic [15:0] pd,
                                    logic [5:0] r, logic [5:0] c, logic orn);
        t_req q;
        q.action = act; q.accept_draw = ad; q.pick_draw = pd;
        q.row = r; q.col = c; q.orientation = orn;
        return q;
    endfunction

    // Sends one request with a random lead gap; queues the predicted response.
    // Valid stays up after acceptance so a zero gap gives back-to-back requests.
    task automatic send_req(t_req q, bit use_typed, t_rsp typed);
        t_rsp p;
        int   gap;
        gap = $urandom_range(0, 11);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tdata  <= {2'b00, q};
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (s_axis_tready !== 1'b1) @(posedge i_clk);
        p = predict_move(q);
        // Typed rows must agree with the predictor as well as with the block
        if (use_typed && p !== typed) begin
            $display("%0t predictor disagrees with table: exp %h got %h", $time, typed, p);
            errors++;
        end
        rsp_pending.push_back(p);
    endtask

    // Writes activity only once the block has drained
    task automatic write_activity(logic [23:0] v);
        s_axis_tvalid <= 1'b0;
        while (rsp_pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        activity_q = v;
    endtask

    // Response side: random stalls, compare with the oldest prediction
    initial begin : rsp_monitor
        t_rsp got, want;
        int   stall;
        m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = $urandom_range(0, 11);
            if ($urandom_range(0, 3) == 0) stall = 0;
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (m_axis_tvalid !== 1'b1) @(posedge i_clk);
            got = t_rsp'(m_axis_tdata[66:0]);
            if (rsp_pending.size() == 0) begin
                $display("%0t unexpected response: got %h", $time, got);
                errors++;
            end else begin
                want = rsp_pending.pop_front();
                if (got.outcome !== want.outcome) begin
                    $display("%0t outcome: exp %0d got %0d", $time, want.outcome, got.outcome);
                    errors++;
                end
                if (got.rod_row !== want.rod_row) begin
                    $display("%0t rod_row: exp %0d got %0d", $time, want.rod_row, got.rod_row);
                    errors++;
                end
                if (got.rod_col !== want.rod_col) begin
                    $display("%0t rod_col: exp %0d got %0d", $time, want.rod_col, got.rod_col);
                    errors++;
                end
                if (got.rod_orientation !== want.rod_orientation) begin
                    $display("%0t rod_orientation: exp %0d got %0d", $time,
                             want.rod_orientation, got.rod_orientation);
                    errors++;
                end
                if (got.horizontal_total !== want.horizontal_total) begin
                    $display("%0t horizontal_total: exp %0d got %0d", $time,
                             want.horizontal_total, got.horizontal_total);
                    errors++;
                end
                if (got.vertical_total !== want.vertical_total) begin
                    $display("%0t vertical_total: exp %0d got %0d", $time,
                             want.vertical_total, got.vertical_total);
                    errors++;
                end
                if (got.accepted_removals !== want.accepted_removals) begin
                    $display("%0t accepted_removals: exp %0d got %0d", $time,
                             want.accepted_removals, got.accepted_removals);
                    errors++;
                end
            end
        end
    end

    // Hard stop: sized for the worst case of ~1100 requests plus drains
    initial begin : watchdog
        #20000000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin : stimulus
        t_row tbl [$];
        t_req q;
        t_rsp r;
        logic [23:0] act_set [4];

        errors = 0;
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        foreach (occ[i]) occ[i] = CELL_EMPTY;
        hcnt = 0; vcnt = 0; removals = 0;
        activity_q = ACT_RESET;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table. Typed rows: removal on an empty lattice, first
        // inserts at the extremes, and overlaps that must be blocked.
        r = '0; r.outcome = OUT_REJECTED;
        tbl.push_back('{mk_req(ACT_REMOVE, 16'h0000, 16'hFFFF, 6'd0, 6'd0, 1'b0), 1, r});
        r = '0; r.outcome = OUT_INSERTED; r.rod_row = 6'd63; r.rod_col = 6'd63;
        r.rod_orientation = OR_HORIZ; r.horizontal_total = 10'd1;
        // horizontal rod wrapping across the right edge
        tbl.push_back('{mk_req(ACT_INSERT, 16'hFFFF, 16'hFFFF, 6'd63, 6'd63, OR_HORIZ), 1, r});
        r = '0; r.outcome = OUT_BLOCKED; r.horizontal_total = 10'd1;
        tbl.push_back('{mk_req(ACT_INSERT, 16'h0000, 16'h0000, 6'd63, 6'd2, OR_HORIZ), 1, r});
        r = '0; r.outcome = OUT_INSERTED; r.rod_row = 6'd60; r.rod_col = 6'd10;
        r.horizontal_total = 10'd1; r.vertical_total = 10'd1;
        // vertical rod wrapping across the bottom edge
        tbl.push_back('{mk_req(ACT_INSERT, 16'h0000, 16'h0000, 6'd60, 6'd10, OR_VERT), 1, r});
        r = '0; r.outcome = OUT_BLOCKED; r.horizontal_total = 10'd1;
        r.vertical_total = 10'd1;
        // vertical rod crossing the wrapped horizontal one
        tbl.push_back('{mk_req(ACT_INSERT, 16'h0000, 16'h0000, 6'd58, 6'd63, OR_VERT), 1, r});
        r = '0;
        for (int i = 0; i < 6; i++)
            tbl.push_back('{mk_req(ACT_INSERT, 16'h0, 16'h0, 6'(i*9), 6'(10+i*7), 1'(i)), 0, r});
        tbl.push_back('{mk_req(ACT_REMOVE, 16'hFFFF, 16'hFFFF, 6'd0, 6'd0, 1'b0), 0, r});
        tbl.push_back('{mk_req(ACT_REMOVE, 16'h0000, 16'h0000, 6'd0, 6'd0, 1'b0), 0, r});
        tbl.push_back('{mk_req(ACT_REMOVE, 16'h0001, 16'h8000, 6'd0, 6'd0, 1'b0), 0, r});
        tbl.push_back('{mk_req(ACT_REMOVE, 16'h4000, 16'hFFFF, 6'd0, 6'd0, 1'b0), 0, r});
        foreach (tbl[i]) send_req(tbl[i].req, tbl[i].chk, tbl[i].rsp);

        // Zero activity: every removal accepted while rods remain
        write_activity(24'd0);
        for (int i = 0; i < 6; i++)
            send_req(mk_req(ACT_REMOVE, 16'hFFFF, 16'($urandom), 6'd0, 6'd0, 1'b0), 0, r);

        // Random phases across several activity settings, the maximum included.
        // Inserts are 70 percent of each phase so the lists fill up.
        act_set = '{24'hFFFFFF, 24'd4096, ACT_RESET, 24'd1200};
        for (int ph = 0; ph < 4; ph++) begin
            write_activity(act_set[ph]);
            for (int i = 0; i < N_RANDOM / 4; i++) begin
                q = mk_req(($urandom_range(0, 99) < 70) ? ACT_INSERT : ACT_REMOVE,
                           16'($urandom), 16'($urandom), 6'($urandom),
                           6'($urandom), 1'($urandom));
                send_req(q, 0, r);
            end
        end

        // Fill one list to its depth with non-overlapping horizontal rods
        write_activity(24'hFFFFFF);
        for (int i = 0; i < 520; i++)
            send_req(mk_req(ACT_INSERT, 16'h0, 16'h0, 6'(i / 8), 6'((i % 8) * 8),
                            OR_HORIZ), 0, r);
        // Overflow attempt on a free spot cannot happen here since lattice is
        // full; remove a few at zero activity.
        write_activity(24'd0);
        for (int i = 0; i < 4; i++)
            send_req(mk_req(ACT_REMOVE, 16'($urandom), 16'($urandom), 6'd0, 6'd0, 1'b0), 0, r);

        s_axis_tvalid <= 1'b0;
        while (rsp_pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
